// ===== src/dapt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the DNS address query pair tracker.
// Holds opcodes, answer codes, the pair transition table and its flag bits.
// No dependencies.
package dapt_pkg;

  // Input opcodes
  typedef enum logic [1:0] {
    OP_QUESTION = 2'd0,
    OP_FAILURE  = 2'd1,
    OP_SUCCESS  = 2'd2,
    OP_UNUSED   = 2'd3
  } opcode_t;

  // Answer codes
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_PASS   = 3'd1,
    ACT_FAIL   = 3'd2,
    ACT_NXD    = 3'd3,
    ACT_NODATA = 3'd4
  } action_t;

  // Register indexes
  localparam logic REG_PAIR_ENABLE = 1'b0;

  // Table entry flag bits; low three bits are the next state
  localparam int BIT_FAIL   = 4;
  localparam int BIT_NXD    = 5;
  localparam int BIT_NODATA = 6;
  localparam int BIT_PASS   = 7;

  // Bit 3 of a pair record: AAAA was the type asked
  localparam int INFO_AAAA = 3;

  localparam logic [2:0] ST_FINAL   = 3'd5;
  localparam logic [2:0] ST_INVALID = 3'd6;
  localparam logic [7:0] ENTRY_BAD  = 8'h06;

  // Transition table: rows are states 0..4, columns event + 3 for aux
  localparam logic [7:0] TRANS [5][6] = '{
    '{8'h11, 8'h03, 8'h81, 8'h02, 8'h02, 8'h04},
    '{8'h06, 8'h06, 8'h06, 8'h05, 8'h05, 8'h05},
    '{8'h15, 8'h25, 8'h85, 8'h06, 8'h06, 8'h06},
    '{8'h06, 8'h06, 8'h06, 8'h25, 8'h25, 8'h45},
    '{8'h15, 8'h45, 8'h85, 8'h06, 8'h06, 8'h06}
  };

  // Result transaction
  typedef struct packed {
    logic       alloc_fail;
    logic       table_error;
    logic       split;
    logic [4:0] new_tag;
    logic       for_aux;
    logic [2:0] action;
  } result_t;

endpackage

// ===== src/dapt_free_find.sv =====
`timescale 1ns / 1ps
// Lowest free pair slot finder.
// Isolates the lowest clear bit with one two's complement add, then encodes it.
// No dependencies.
module dapt_free_find #(
  parameter int SLOTS  = 16,
  parameter int SLOT_W = 4
) (
  input  logic [SLOTS-1:0]  used,
  output logic              found,
  output logic [SLOT_W-1:0] idx
);

  logic [SLOTS-1:0] free_bits;
  logic [SLOTS-1:0] lowest;

  // One-hot of the lowest free slot
  assign free_bits = ~used;
  assign lowest    = free_bits & (~free_bits + SLOTS'(1));
  assign found     = |free_bits;

  // Encode the one-hot; each bit contributes its own index
  always_comb begin
    idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (lowest[i]) begin
        idx = idx | SLOT_W'(i);
      end
    end
  end

endmodule

// ===== src/dns_address_query_pair_tracker.sv =====
`timescale 1ns / 1ps
// DNS address query pair tracker, top level.
// A taken item is held while its pair record is read from a registered memory,
// then stepped and written back as its result enters the output register; no new
// item is taken until the held one has been passed on.
// Reset (rst, synchronous): slot flags free, pairing disabled; records undefined.
// Depends on dapt_pkg and dapt_free_find.
module dns_address_query_pair_tracker #(
  parameter int PAIR_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] address_query, [1] asked_aaaa, [6:2] slot_tag, [7] reply_is_aaaa,
  // [8] is_nxdomain, [15:9] zero
  input  logic [15:0] s_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_tuser,
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] action, [3] for_aux, [8:4] new_tag, [9] split, [10] table_error,
  // [11] alloc_fail, [15:12] zero
  output logic [15:0] m_tdata,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SLOT_W = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
  localparam int CMP_W  = (SLOT_W + 1 > 5) ? SLOT_W + 1 : 5;
  localparam logic [CMP_W-1:0] SLOTS_C = CMP_W'(PAIR_SLOTS);
  localparam logic REG_PAIR_ENABLE_BIT = dapt_pkg::REG_PAIR_ENABLE;

  // Configuration register
  logic pair_enable;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_enable <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_PAIR_ENABLE_BIT) begin
      pair_enable <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_PAIR_ENABLE_BIT) ? {31'd0, pair_enable} : 32'd0;

  // Input fields
  logic [4:0]       in_tag;
  logic [CMP_W-1:0] in_tagx;
  logic             in_range;
  logic             accept;

  assign in_tag   = s_tdata[6:2];
  assign in_tagx  = CMP_W'(in_tag);
  assign in_range = (in_tag != 5'd0) && (in_tagx <= SLOTS_C);
  assign accept   = s_tvalid && s_tready;

  // Held item
  logic                busy;
  dapt_pkg::opcode_t   op_q;
  logic                addr_q_q;
  logic                ask6_q;
  logic                rep6_q;
  logic                nxd_q;
  logic                range_q;
  logic [SLOT_W-1:0]   slot_q;

  assign s_tready = !busy;

  // Pair record memory with a registered read
  logic [3:0]        pair_mem [PAIR_SLOTS];
  logic [3:0]        rd_data;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [3:0]        wr_data;

  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      rd_data <= pair_mem[SLOT_W'(in_tagx - CMP_W'(1))];
    end
    if (wr_en) begin
      pair_mem[wr_addr] <= wr_data;
    end
  end

  // Slot occupancy flags
  logic [PAIR_SLOTS-1:0] slot_used;
  logic                  free_found;
  logic [SLOT_W-1:0]     free_idx;

  dapt_free_find #(
    .SLOTS  (PAIR_SLOTS),
    .SLOT_W (SLOT_W)
  ) u_free_find (
    .used  (slot_used),
    .found (free_found),
    .idx   (free_idx)
  );

  // Step the held item against its record
  logic                done;
  dapt_pkg::result_t   res;
  logic                set_used;
  logic                clr_used;
  logic [2:0]          st;
  logic [2:0]          st_new;
  logic [1:0]          ev;
  logic                isaux;
  logic [2:0]          col;
  logic [7:0]          entry;
  logic                paired;

  assign done = busy && (!m_tvalid || m_tready);

  always_comb begin
    res      = '0;
    set_used = 1'b0;
    clr_used = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = slot_q;
    wr_data  = rd_data;
    paired   = pair_enable && range_q;
    st       = rd_data[2:0];
    ev       = (op_q == dapt_pkg::OP_FAILURE) ? 2'd0 : (nxd_q ? 2'd1 : 2'd2);
    isaux    = rd_data[dapt_pkg::INFO_AAAA] ^ rep6_q;
    col      = 3'(ev) + (isaux ? 3'd3 : 3'd0);
    entry    = (st >= dapt_pkg::ST_FINAL) ? dapt_pkg::ENTRY_BAD : dapt_pkg::TRANS[st][col];
    st_new   = entry[2:0];
    case (op_q)
      dapt_pkg::OP_QUESTION: begin
        if (pair_enable && addr_q_q) begin
          if (free_found) begin
            set_used    = done;
            wr_en       = done;
            wr_addr     = free_idx;
            wr_data     = {ask6_q, 3'd0};
            res.new_tag = 5'({1'b0, free_idx} + (SLOT_W + 1)'(1));
            res.split   = 1'b1;
          end else begin
            res.alloc_fail = 1'b1;
          end
        end
      end
      dapt_pkg::OP_FAILURE, dapt_pkg::OP_SUCCESS: begin
        if (paired) begin
          wr_en   = done;
          wr_data = {rd_data[dapt_pkg::INFO_AAAA], st_new};
          if (entry[dapt_pkg::BIT_FAIL]) begin
            res.action  = dapt_pkg::ACT_FAIL;
            res.for_aux = isaux;
          end else if (entry[dapt_pkg::BIT_NXD]) begin
            res.action  = dapt_pkg::ACT_NXD;
            res.for_aux = isaux;
          end else if (entry[dapt_pkg::BIT_NODATA]) begin
            res.action  = dapt_pkg::ACT_NODATA;
            res.for_aux = isaux;
          end
          res.table_error = (st_new >= dapt_pkg::ST_INVALID);
          clr_used        = done && (st_new == dapt_pkg::ST_FINAL);
        end
        // Unpaired or pass-through responses
        if (!paired || entry[dapt_pkg::BIT_PASS]) begin
          res.action  = (op_q == dapt_pkg::OP_FAILURE) ? dapt_pkg::ACT_FAIL
                                                       : dapt_pkg::ACT_PASS;
          res.for_aux = 1'b0;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Control and holding registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= dapt_pkg::opcode_t'(s_tuser);
      addr_q_q <= s_tdata[0];
      ask6_q   <= s_tdata[1];
      rep6_q   <= s_tdata[7];
      nxd_q    <= s_tdata[8];
      range_q  <= in_range;
      slot_q   <= SLOT_W'(in_tagx - CMP_W'(1));
    end
    if (done) begin
      m_tdata <= {4'd0, res};
    end
  end

  // Slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
    end else if (set_used) begin
      slot_used[free_idx] <= 1'b1;
    end else if (clr_used) begin
      slot_used[slot_q] <= 1'b0;
    end
  end

  // A held item reaches a free output register in the next cycle
  a_deliver: assert property (@(posedge clk) disable iff (rst)
    (busy && !m_tvalid) |=> (m_tvalid && !busy))
    else $error("held item not delivered");

  // Granting a slot raises occupancy by one
  a_grant_count: assert property (@(posedge clk) disable iff (rst)
    (done && res.split) |=> ($countones(slot_used) == $past($countones(slot_used)) + 1))
    else $error("slot grant did not mark one slot");

  // Allocation fails only with every slot taken
  a_alloc_full: assert property (@(posedge clk) disable iff (rst)
    (done && res.alloc_fail) |-> (&slot_used))
    else $error("allocation failed with a free slot");

  // A question result never carries a table error
  a_question_clean: assert property (@(posedge clk) disable iff (rst)
    (done && op_q == dapt_pkg::OP_QUESTION) |->
      (!res.table_error && res.action == dapt_pkg::ACT_NONE))
    else $error("question result carries response fields");

endmodule
